/* rtl/fscr_pkg.sv */
// Shared types and constants for the framed serial command receiver.
package fscr_pkg;

    // Request codes carried on s_tuser.
    localparam logic [1:0] REQ_ARM    = 2'd0;
    localparam logic [1:0] REQ_BYTE   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Result kinds carried on m_tuser.
    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_FINISH  = 1'b1;

    localparam logic [7:0]  HEAD_BYTE     = 8'h7E;
    localparam logic [31:0] TIMEOUT_RESET = 32'd25000000;
    localparam int          QUEUE_DEPTH   = 4;

    localparam int STATUS_W = 9;
    localparam int IN_DATA_W = 8;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 64;

    // Classified request as it travels from front to back.
    typedef struct packed {
        logic       arm;
        logic       take_byte;
        logic       tick;
        logic [7:0] rx_byte;
    } cmd_t;

endpackage

/* rtl/framed_serial_command_receiver.sv */
// Top level of the framed serial command receiver: timeout register, front and back parts.
//
// Usage:
//   Input words (s_): s_tuser carries the request (arm, received byte, idle tick),
//   s_tdata the received byte. An arm starts a new frame and drops any frame in
//   progress. Bytes and ticks are ignored until the receiver is armed.
//   Output words (m_): either one payload byte as it arrives (m_tuser = 0) or one
//   finish word with the frame status (m_tuser = 1). Bad head, timeouts and
//   checksum mismatch end the frame; the receiver then waits for the next arm.
//   cfg_we/cfg_wdata load the idle timeout in ticks; write it only while idle.
// Path and throughput:
//   A word taken on s_ passes through the queue and then the output register
//   before it appears on m_. One word per cycle is sustained while m_tready is high;
//   the parser state update in the back part is the per-cycle limit.
// Reset and stall:
//   aresetn (synchronous, active low) empties the queue, drops any frame and
//   restores the timeout to its default. When m_tready is low, the back part
//   holds its result and stops; the queue keeps taking words until it fills,
//   then s_tready drops.
module framed_serial_command_receiver #(
    parameter int QueueDepth = fscr_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: timeout_ticks
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fscr_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [fscr_pkg::IN_USER_W-1:0]  s_tuser,   // [1:0] req_type
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [8:0] status, [16:9] data_byte, [24:17] byte_index, [32:25] frame_number,
    // [40:33] command_code, [48:41] reserved_field, [56:49] payload_length,
    // [63:57] zero
    output logic [fscr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser    // [0] result_kind
);
    import fscr_pkg::*;

    logic [31:0] timeout_reg, timeout_next;
    logic        q_valid;
    cmd_t        q_item;
    logic        q_pop;

    // Load the timeout on every write strobe.
    assign timeout_next = cfg_we ? cfg_wdata : timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            timeout_reg <= timeout_next;
        end
    end

    fscr_front #(
        .Depth (QueueDepth)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    fscr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .timeout_ticks (timeout_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

/* rtl/fscr_front.sv */
// Front part: accept input words, classify the request and queue it for the back part.
module fscr_front #(
    parameter int Depth = fscr_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fscr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [fscr_pkg::IN_USER_W-1:0] s_tuser,
    output logic                           q_valid,
    output fscr_pkg::cmd_t                 q_item,
    input  logic                           q_pop
);
    import fscr_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    cmd_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    cmd_t            cls;
    logic            push;
    logic            pop;

    // Decode the request; the unused code is accepted and dropped here.
    always_comb begin
        cls.arm       = (s_tuser == REQ_ARM);
        cls.take_byte = (s_tuser == REQ_BYTE);
        cls.tick      = (s_tuser == REQ_TICK);
        cls.rx_byte   = s_tdata;
    end

    assign s_tready = (cnt_reg != FullCnt);
    assign push     = s_tvalid && s_tready && (s_tuser != REQ_UNUSED);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/fscr_back.sv */
// Back part: frame parser, checksum, timeout counter and the output register.
module fscr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [31:0]                     timeout_ticks,
    input  logic                            q_valid,
    input  fscr_pkg::cmd_t                  q_item,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fscr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser
);
    import fscr_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_NUM  = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_RSV  = 3'd4;
    localparam logic [2:0] PH_LEN  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_SUM  = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 9'd0;
    localparam logic [STATUS_W-1:0] ST_HEAD     = 9'd1;
    localparam logic [STATUS_W-1:0] ST_NUM      = 9'd2;
    localparam logic [STATUS_W-1:0] ST_CMD      = 9'd3;
    localparam logic [STATUS_W-1:0] ST_RSV      = 9'd4;
    localparam logic [STATUS_W-1:0] ST_LEN      = 9'd5;
    localparam logic [STATUS_W-1:0] ST_BASE     = 9'd6;
    localparam logic [STATUS_W-1:0] ST_SUM_FAIL = 9'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] idle_reg, idle_next;
    logic [7:0]  fnum_reg, fnum_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  rsv_reg, rsv_next;
    logic [7:0]  len_reg, len_next;

    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                m_kind_reg;

    logic                emit;
    logic                res_kind;
    logic [STATUS_W-1:0] res_status;
    logic [7:0]          res_data;
    logic [7:0]          res_index;
    logic [31:0]         idle_inc;
    logic [7:0]          count_inc;
    logic [7:0]          rx;

    // Take the next queued request whenever the output register is free or draining.
    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign idle_inc = (idle_reg == 32'hFFFF_FFFF) ? idle_reg : idle_reg + 32'd1;
    assign count_inc = count_reg + 8'd1;
    assign rx       = q_item.rx_byte;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        fnum_next  = fnum_reg;
        cmd_next   = cmd_reg;
        rsv_next   = rsv_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        res_kind   = RES_FINISH;
        res_status = ST_OK;
        res_data   = 8'd0;
        res_index  = 8'd0;
        if (q_pop) begin
            if (q_item.arm) begin
                phase_next = PH_HEAD;
                sum_next   = '0;
                count_next = '0;
                idle_next  = '0;
                fnum_next  = '0;
                cmd_next   = '0;
                rsv_next   = '0;
                len_next   = '0;
            end else if (q_item.take_byte && phase_reg != PH_IDLE) begin
                idle_next = '0;
                case (phase_reg)
                    PH_HEAD: begin
                        if (rx != HEAD_BYTE) begin
                            emit       = 1'b1;
                            res_status = ST_HEAD;
                            res_data   = rx;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_NUM;
                        end
                    end
                    PH_NUM: begin
                        fnum_next  = rx;
                        sum_next   = rx;
                        phase_next = PH_CMD;
                    end
                    PH_CMD: begin
                        cmd_next   = rx;
                        sum_next   = sum_reg + rx;
                        phase_next = PH_RSV;
                    end
                    PH_RSV: begin
                        rsv_next   = rx;
                        sum_next   = sum_reg + rx;
                        phase_next = PH_LEN;
                    end
                    PH_LEN: begin
                        len_next   = rx;
                        sum_next   = sum_reg + rx;
                        phase_next = (rx == 8'd0) ? PH_SUM : PH_DATA;
                    end
                    PH_DATA: begin
                        sum_next   = sum_reg + rx;
                        count_next = count_inc;
                        if (count_inc >= len_reg) begin
                            phase_next = PH_SUM;
                        end
                        emit      = 1'b1;
                        res_kind  = RES_PAYLOAD;
                        res_data  = rx;
                        res_index = count_reg;
                    end
                    PH_SUM: begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                        res_status = (sum_reg == rx) ? ST_OK
                                   : ST_SUM_FAIL + STATUS_W'(len_reg);
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end else if (q_item.tick && phase_reg != PH_IDLE) begin
                idle_next = idle_inc;
                if (idle_inc >= timeout_ticks) begin
                    idle_next  = '0;
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    case (phase_reg)
                        PH_HEAD: res_status = ST_HEAD;
                        PH_NUM:  res_status = ST_NUM;
                        PH_CMD:  res_status = ST_CMD;
                        PH_RSV:  res_status = ST_RSV;
                        PH_LEN:  res_status = ST_LEN;
                        PH_DATA: res_status = ST_BASE + STATUS_W'(count_reg);
                        default: res_status = ST_BASE + STATUS_W'(len_reg);
                    endcase
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop && emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            idle_reg    <= '0;
            fnum_reg    <= '0;
            cmd_reg     <= '0;
            rsv_reg     <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            idle_reg    <= idle_next;
            fnum_reg    <= fnum_next;
            cmd_reg     <= cmd_next;
            rsv_reg     <= rsv_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Header fields in the result are those held before this word is applied.
    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            m_kind_reg <= res_kind;
            m_data_reg <= {7'd0, len_reg, rsv_reg, cmd_reg, fnum_reg,
                           res_index, res_data, res_status};
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_kind_reg;

endmodule

/* verif/fscr_checker.sv */
`timescale 1ns / 100ps
// Watches both streams of the frame receiver, predicts every result word and compares it.
module fscr_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fscr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [fscr_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fscr_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic [0:0]                      m_tuser,
    output int                              fail_count,
    output int                              words_taken,
    output int                              results_due,
    output int                              payload_seen,
    output int                              finish_seen
);
    import fscr_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_NUM  = 3'd2;
    localparam logic [2:0] PH_CMD  = 3'd3;
    localparam logic [2:0] PH_RSV  = 3'd4;
    localparam logic [2:0] PH_LEN  = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;
    localparam logic [2:0] PH_SUM  = 3'd7;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [7:0]          data_byte;
        logic [7:0]          byte_index;
        logic [7:0]          frame_number;
        logic [7:0]          command_code;
        logic [7:0]          reserved_field;
        logic [7:0]          payload_length;
    } frame_word_t;

    localparam logic [STATUS_W-1:0] STAT_OK           = 9'd0;
    localparam logic [STATUS_W-1:0] STAT_HEAD         = 9'd1;
    localparam logic [STATUS_W-1:0] STAT_TMO_NUM      = 9'd2;
    localparam logic [STATUS_W-1:0] STAT_TMO_CMD      = 9'd3;
    localparam logic [STATUS_W-1:0] STAT_TMO_RSV      = 9'd4;
    localparam logic [STATUS_W-1:0] STAT_TMO_LEN      = 9'd5;
    localparam logic [STATUS_W-1:0] STAT_PAYLOAD_BASE = 9'd6;

    logic [31:0]  tmo_limit;
    logic [2:0]   cur_phase;
    logic [7:0]   sum_acc;
    logic [7:0]   data_count;
    logic [31:0]  quiet_ticks;
    logic [7:0]   hdr_num;
    logic [7:0]   hdr_cmd;
    logic [7:0]   hdr_rsv;
    logic [7:0]   hdr_len;

    frame_word_t awaited_words[$];

    function automatic frame_word_t compose(input logic kind, input logic [STATUS_W-1:0] status,
                                            input logic [7:0] data, input logic [7:0] idx);
        frame_word_t w;
        w.kind           = kind;
        w.status         = status;
        w.data_byte      = data;
        w.byte_index     = idx;
        w.frame_number   = hdr_num;
        w.command_code   = hdr_cmd;
        w.reserved_field = hdr_rsv;
        w.payload_length = hdr_len;
        return w;
    endfunction

    task automatic clear_frame();
        sum_acc     = '0;
        data_count  = '0;
        quiet_ticks = '0;
        hdr_num     = '0;
        hdr_cmd     = '0;
        hdr_rsv     = '0;
        hdr_len     = '0;
    endtask

    // One accepted request through the frame parser; at most one result word.
    task automatic step_frame_parser(input logic [1:0] req, input logic [7:0] b,
                                     output bit made, output frame_word_t w);
        logic [STATUS_W-1:0] status;
        logic [7:0]          idx;
        made = 1'b0;
        w    = '0;
        case (req)
            REQ_ARM: begin
                clear_frame();
                cur_phase = PH_HEAD;
            end
            REQ_BYTE: begin
                if (cur_phase != PH_IDLE) begin
                    quiet_ticks = '0;
                    case (cur_phase)
                        PH_HEAD: begin
                            if (b != HEAD_BYTE) begin
                                cur_phase = PH_IDLE;
                                w    = compose(RES_FINISH, STAT_HEAD, b, 8'd0);
                                made = 1'b1;
                            end else begin
                                cur_phase = PH_NUM;
                            end
                        end
                        PH_NUM: begin
                            hdr_num   = b;
                            sum_acc   = b;
                            cur_phase = PH_CMD;
                        end
                        PH_CMD: begin
                            hdr_cmd   = b;
                            sum_acc   = sum_acc + b;
                            cur_phase = PH_RSV;
                        end
                        PH_RSV: begin
                            hdr_rsv   = b;
                            sum_acc   = sum_acc + b;
                            cur_phase = PH_LEN;
                        end
                        PH_LEN: begin
                            hdr_len   = b;
                            sum_acc   = sum_acc + b;
                            cur_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                            idx        = data_count;
                            sum_acc    = sum_acc + b;
                            data_count = data_count + 8'd1;
                            if (data_count >= hdr_len) begin
                                cur_phase = PH_SUM;
                            end
                            w    = compose(RES_PAYLOAD, STAT_OK, b, idx);
                            made = 1'b1;
                        end
                        PH_SUM: begin
                            status = (sum_acc == b) ? STAT_OK
                                   : STAT_PAYLOAD_BASE + 9'(hdr_len) + 9'd1;
                            cur_phase = PH_IDLE;
                            w    = compose(RES_FINISH, status, 8'd0, 8'd0);
                            made = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            REQ_TICK: begin
                if (cur_phase != PH_IDLE) begin
                    if (quiet_ticks != '1) begin
                        quiet_ticks = quiet_ticks + 32'd1;
                    end
                    if (quiet_ticks >= tmo_limit) begin
                        case (cur_phase)
                            PH_HEAD: status = STAT_HEAD;
                            PH_NUM:  status = STAT_TMO_NUM;
                            PH_CMD:  status = STAT_TMO_CMD;
                            PH_RSV:  status = STAT_TMO_RSV;
                            PH_LEN:  status = STAT_TMO_LEN;
                            PH_DATA: status = STAT_PAYLOAD_BASE + 9'(data_count);
                            default: status = STAT_PAYLOAD_BASE + 9'(hdr_len);
                        endcase
                        quiet_ticks = '0;
                        cur_phase   = PH_IDLE;
                        w    = compose(RES_FINISH, status, 8'd0, 8'd0);
                        made = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_word_t seen;
        frame_word_t want;
        bit          made;
        if (!aresetn) begin
            tmo_limit = TIMEOUT_RESET;
            cur_phase = PH_IDLE;
            clear_frame();
            awaited_words.delete();
            words_taken <= 0;
            results_due <= 0;
        end else begin
            if (cfg_we) begin
                tmo_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                step_frame_parser(s_tuser, s_tdata[7:0], made, want);
                if (made) begin
                    awaited_words.push_back(want);
                end
                words_taken <= words_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                seen.kind           = m_tuser[0];
                seen.status         = m_tdata[8:0];
                seen.data_byte      = m_tdata[16:9];
                seen.byte_index     = m_tdata[24:17];
                seen.frame_number   = m_tdata[32:25];
                seen.command_code   = m_tdata[40:33];
                seen.reserved_field = m_tdata[48:41];
                seen.payload_length = m_tdata[56:49];
                if (seen.kind == RES_PAYLOAD) begin
                    payload_seen++;
                end else begin
                    finish_seen++;
                end
                if (awaited_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, %s %0d status %0d",
                             $time, "actual kind", seen.kind, seen.status);
                    fail_count++;
                end else begin
                    want = awaited_words.pop_front();
                    check_field("result_kind", want.kind, seen.kind);
                    check_field("status", want.status, seen.status);
                    check_field("data_byte", want.data_byte, seen.data_byte);
                    check_field("byte_index", want.byte_index, seen.byte_index);
                    check_field("frame_number", want.frame_number, seen.frame_number);
                    check_field("command_code", want.command_code, seen.command_code);
                    check_field("reserved_field", want.reserved_field, seen.reserved_field);
                    check_field("payload_length", want.payload_length, seen.payload_length);
                end
            end
            results_due <= awaited_words.size();
        end
    end

endmodule

/* verif/framed_serial_command_receiver_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the frame receiver: clock, reset, stimulus, stall patterns and verdict.
module framed_serial_command_receiver_tb;
    import fscr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    // Words can still sit in the queue or output register when the last result lands.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 720;
    localparam int PHASE_COUNT   = 6;
    localparam int CYCLE_LIMIT   = 2000000;

    // How a generated frame ends.
    typedef enum int {TAIL_GOOD, TAIL_BAD, TAIL_TIMEOUT} frame_tail_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [31:0]           cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = REQ_ARM;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    int fail_count;
    int words_taken;
    int results_due;
    int payload_seen;
    int finish_seen;

    int          words_sent     = 0;
    int          noise_words    = 0;
    int          long_holds     = 0;
    int          settings_used  = 0;
    int          cycle_count    = 0;
    int          tx_gap_max     = 12;
    logic [31:0] cur_tmo        = TIMEOUT_RESET;
    bit          hold_request   = 1'b0;

    framed_serial_command_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    fscr_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .words_taken  (words_taken),
        .results_due  (results_due),
        .payload_seen (payload_seen),
        .finish_seen  (finish_seen)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles, %0d results still due",
                     cycle_count, results_due);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: stall a random number of cycles per word, with calm stretches
    // where it never stalls, and a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int stall;
        int mode_left;
        bit calm;
        mode_left = 0;
        calm      = 1'b0;
        wait (aresetn);
        forever begin
            if (mode_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                long_holds++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = calm ? 0 : $urandom_range(0, 12);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one word after a random gap; return in the step of its handshake.
    // Valid stays high when the next word follows without a gap.
    task automatic send_word(input logic [1:0] req, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stop offering, wait until the checker has seen every word and every
    // predicted result, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (words_taken != words_sent || results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Load the idle timeout; only called with the receiver drained.
    task automatic write_timeout(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_tmo   = value;
        settings_used++;
    endtask

    // Ticks needed to expire the awaited byte; a zero setting acts as one.
    function automatic int unsigned tick_budget();
        return (cur_tmo == 32'd0) ? 1 : cur_tmo;
    endfunction

    // Maybe insert idle ticks ahead of a byte; with a short timeout the run of
    // ticks sometimes reaches it and the frame is over.
    task automatic idle_ticks(input int pct, output bit expired);
        int unsigned limit;
        int unsigned n;
        expired = 1'b0;
        if ($urandom_range(0, 99) >= pct) begin
            return;
        end
        limit = tick_budget();
        n = (limit <= 8) ? $urandom_range(0, limit) : $urandom_range(1, 4);
        repeat (n) send_word(REQ_TICK, 8'($urandom));
        expired = (n >= limit);
    endtask

    // Frame with random header and payload content; the tail is a good or bad checksum or a timeout.
    task automatic send_frame(input int len, input frame_tail_t tail, input int tick_pct);
        logic [7:0] hdr[4];
        logic [7:0] sum;
        logic [7:0] b;
        bit         expired;
        int         i;
        sum = 8'd0;
        for (i = 0; i < 4; i++) begin
            hdr[i] = 8'($urandom);
        end
        hdr[3] = 8'(len);
        send_word(REQ_ARM, 8'($urandom));
        idle_ticks(tick_pct, expired);
        if (expired) begin
            return;
        end
        send_word(REQ_BYTE, HEAD_BYTE);
        for (i = 0; i < 4; i++) begin
            idle_ticks(tick_pct, expired);
            if (expired) begin
                return;
            end
            send_word(REQ_BYTE, hdr[i]);
            sum = sum + hdr[i];
        end
        for (i = 0; i < len; i++) begin
            idle_ticks(tick_pct, expired);
            if (expired) begin
                return;
            end
            b   = 8'($urandom);
            sum = sum + b;
            send_word(REQ_BYTE, b);
        end
        case (tail)
            TAIL_GOOD: begin
                send_word(REQ_BYTE, sum);
            end
            TAIL_BAD: begin
                send_word(REQ_BYTE, sum ^ 8'($urandom_range(1, 255)));
            end
            default: begin
                // Expire the checksum wait; with a long timeout the frame stays
                // open and the next arm drops it.
                if (tick_budget() <= 8) begin
                    repeat (tick_budget()) send_word(REQ_TICK, 8'($urandom));
                end
            end
        endcase
    endtask

    // Broken frames: bad head, cut short, or cut short and left to time out.
    task automatic send_broken();
        logic [7:0] b;
        int         kind;
        int         n;
        kind = $urandom_range(0, 2);
        send_word(REQ_ARM, 8'($urandom));
        if (kind == 0) begin
            b = 8'($urandom);
            if (b == HEAD_BYTE) begin
                b = ~b;
            end
            send_word(REQ_BYTE, b);
        end else begin
            if ($urandom_range(0, 3) != 0) begin
                send_word(REQ_BYTE, HEAD_BYTE);
                n = $urandom_range(0, 8);
                repeat (n) send_word(REQ_BYTE, 8'($urandom));
            end
            if (kind == 2 && tick_budget() <= 8) begin
                repeat (tick_budget()) send_word(REQ_TICK, 8'($urandom));
            end
        end
    endtask

    // Anything at all, including the unused request code.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        noise_words += n;
        repeat (n) send_word(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    // One timeout setting: mostly frames, some broken ones, a little noise.
    task automatic run_random_phase(input logic [31:0] tmo, input int quota);
        int          first;
        int          r;
        int          len;
        frame_tail_t tail;
        write_timeout(tmo);
        first = words_sent - noise_words;
        while (words_sent - noise_words - first < quota) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                r = $urandom_range(0, 99);
                len = (r < 60) ? $urandom_range(0, 3)
                    : (r < 92) ? $urandom_range(4, 16) : $urandom_range(17, 64);
                r = $urandom_range(0, 99);
                tail = (r < 70) ? TAIL_GOOD : (r < 90) ? TAIL_BAD : TAIL_TIMEOUT;
                send_frame(len, tail, ($urandom_range(0, 3) == 0) ? 0 : 10);
            end else if (r < 90) begin
                send_broken();
            end else begin
                send_noise();
            end
        end
        drain();
    endtask

    initial begin : stimulus
        logic [31:0] phase_tmo[PHASE_COUNT];
        int          p;
        phase_tmo[0] = 32'd1;
        phase_tmo[1] = 32'hFFFF_FFFF;
        phase_tmo[2] = 32'd2;
        phase_tmo[3] = $urandom_range(3, 8);
        phase_tmo[4] = $urandom;
        phase_tmo[5] = $urandom_range(2, 5);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, default timeout. Not armed yet: all three are dropped.
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_TICK, 8'h00);
        send_word(REQ_UNUSED, 8'hAA);
        // Zero-length frame: checksum right after the length byte, good sum.
        send_word(REQ_ARM, 8'h00);
        send_word(REQ_BYTE, HEAD_BYTE);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'h54);
        // One payload byte, then a checksum that is off by one.
        send_word(REQ_ARM, 8'hFF);
        send_word(REQ_BYTE, HEAD_BYTE);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hAA);
        send_word(REQ_BYTE, 8'h01);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_BYTE, 8'hA8);
        // Wrong head byte is reported back.
        send_word(REQ_ARM, 8'h00);
        send_word(REQ_BYTE, 8'h81);
        drain();

        // A zero timeout fires on the first tick: head timeout, then a re-arm in
        // the middle of a frame followed by a frame number timeout.
        write_timeout(32'd0);
        send_word(REQ_ARM, 8'h00);
        send_word(REQ_TICK, 8'hFF);
        send_word(REQ_ARM, 8'h00);
        send_word(REQ_BYTE, HEAD_BYTE);
        send_word(REQ_ARM, 8'h00);
        send_word(REQ_BYTE, HEAD_BYTE);
        send_word(REQ_TICK, 8'h00);
        drain();

        // Longest frames back to back while the result side holds off, so the
        // queue fills and input stalls; pause for all results in between.
        write_timeout(32'd1);
        tx_gap_max   = 0;
        hold_request = 1'b1;
        send_frame(255, TAIL_BAD, 0);
        drain();
        hold_request = 1'b1;
        send_frame(255, TAIL_TIMEOUT, 0);
        drain();

        for (p = 0; p < PHASE_COUNT; p++) begin
            run_random_phase(phase_tmo[p], RANDOM_WORDS / PHASE_COUNT);
        end

        $display("sent %0d input words (%0d of them noise) over %0d timeout settings",
                 words_sent, noise_words, settings_used);
        $display("checked %0d payload words and %0d frame endings, %0d long result holds",
                 payload_seen, finish_seen, long_holds);
        if (fail_count == 0 && results_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
